// ----- src/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and constants for the pump fill sequencer
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [5:0] GUARD_MS = 6'd50;

  localparam logic [15:0] MAX_RUN_RST   = 16'd15000;
  localparam logic [15:0] MAX_FLUSH_RST = 16'd60000;
  localparam logic [15:0] RETRACT_RST   = 16'd1500;
  localparam logic [7:0]  BLINK_ON_RST  = 8'd200;
  localparam logic [7:0]  BLINK_OFF_RST = 8'd150;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_RUN     = 3'd1,
    MODE_RETRACT = 3'd2,
    MODE_FLUSH   = 3'd3,
    MODE_STOP    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RW_NONE  = 2'd0,
    RW_START = 2'd1,
    RW_FLUSH = 2'd2
  } rel_wait_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RUN   = 3'd0,
    REG_MAX_FLUSH = 3'd1,
    REG_RETRACT   = 3'd2,
    REG_BLINK_ON  = 3'd3,
    REG_BLINK_OFF = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] max_run_ms;
    logic [15:0] max_flush_ms;
    logic [15:0] retract_ms;
    logic [7:0]  blink_on_ms;
    logic [7:0]  blink_off_ms;
  } cfg_t;

  typedef struct packed {
    logic        pump_forward;
    logic        pump_reverse;
    logic        led_red;
    logic        led_blue;
    mode_e       mode;
    logic        run_finished;
    logic [31:0] total_run_ms;
    logic [31:0] run_count;
  } res_t;

endpackage

// ----- src/pfs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pfs_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module pfs_cfg_regs
  import pfs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_run_ms   <= MAX_RUN_RST;
      cfg_q.max_flush_ms <= MAX_FLUSH_RST;
      cfg_q.retract_ms   <= RETRACT_RST;
      cfg_q.blink_on_ms  <= BLINK_ON_RST;
      cfg_q.blink_off_ms <= BLINK_OFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MAX_RUN:   cfg_q.max_run_ms   <= cfg_wdata_i;
        REG_MAX_FLUSH: cfg_q.max_flush_ms <= cfg_wdata_i;
        REG_RETRACT:   cfg_q.retract_ms   <= cfg_wdata_i;
        REG_BLINK_ON:  cfg_q.blink_on_ms  <= cfg_wdata_i[7:0];
        REG_BLINK_OFF: cfg_q.blink_off_ms <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/pfs_scale.sv -----
// ----------------------------------------------------------------------------
// pfs_scale
// run time from potentiometer level: level * max_run_ms / 2^LEVEL_BITS
// ----------------------------------------------------------------------------
module pfs_scale
  import pfs_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = 12
) (
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [15:0]        max_run_i,
  output logic [15:0]        run_time_o
);

  localparam int unsigned LV_W = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;
  localparam int unsigned P_W  = LV_W + 16;

  logic [P_W-1:0] prod;
  logic [P_W-1:0] shifted;

  assign prod       = {{16{1'b0}}, level_i[LV_W-1:0]} * {{LV_W{1'b0}}, max_run_i};
  assign shifted    = prod >> LEVEL_BITS;
  assign run_time_o = shifted[15:0];

endmodule

// ----- src/pfs_core.sv -----
// ----------------------------------------------------------------------------
// pfs_core
// mode machine, timers, blinking and run totals, one step per tick
// ----------------------------------------------------------------------------
module pfs_core
  import pfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        start_i,
  input  logic        flush_i,
  input  logic        estop_i,
  input  logic [15:0] run_time_i,
  input  cfg_t        cfg_i,
  output res_t        res_o
);

  mode_e       mode_q, mode_d;
  rel_wait_e   rel_wait_q, rel_wait_d;
  logic [15:0] run_timer_q, run_timer_d;
  logic [7:0]  blink_timer_q, blink_timer_d;
  logic        blink_en_q, blink_en_d;
  logic        lamp_q, lamp_d;
  logic        blink_red_q, blink_red_d;
  logic [1:0]  drive_q, drive_d;
  logic [5:0]  guard_q, guard_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] total_q, total_d;
  logic [31:0] runs_q, runs_d;
  logic        finished;
  logic        suspended;

  always_comb begin : next_state
    mode_d        = mode_q;
    rel_wait_d    = rel_wait_q;
    run_timer_d   = run_timer_q;
    blink_timer_d = blink_timer_q;
    blink_en_d    = blink_en_q;
    lamp_d        = lamp_q;
    blink_red_d   = blink_red_q;
    drive_d       = drive_q;
    guard_d       = guard_q;
    elapsed_d     = elapsed_q;
    total_d       = total_q;
    runs_d        = runs_q;
    finished      = 1'b0;
    suspended     = 1'b0;

    if (run_timer_d != '0) run_timer_d = run_timer_d - 16'd1;
    if (blink_timer_d != '0) blink_timer_d = blink_timer_d - 8'd1;
    if (mode_q == MODE_RUN || mode_q == MODE_RETRACT || mode_q == MODE_FLUSH) begin
      elapsed_d = elapsed_d + 32'd1;
    end

    if (estop_i) begin
      blink_en_d  = 1'b0;
      lamp_d      = 1'b1;
      blink_red_d = 1'b1;
      drive_d     = 2'b00;
      mode_d      = MODE_STOP;
      rel_wait_d  = RW_NONE;
      guard_d     = '0;
    end

    if (rel_wait_d == RW_START) begin
      suspended = 1'b1;
      if (run_timer_d == '0) drive_d = drive_d & 2'b10;
      if (!start_i) begin
        rel_wait_d = RW_NONE;
        guard_d    = GUARD_MS;
      end
    end else if (rel_wait_d == RW_FLUSH) begin
      suspended = 1'b1;
      if (!start_i) begin
        rel_wait_d = RW_NONE;
        mode_d     = MODE_IDLE;
        total_d    = total_d + elapsed_d;
        runs_d     = runs_d + 32'd1;
        finished   = 1'b1;
      end
    end else if (guard_d != '0) begin
      suspended = 1'b1;
      guard_d   = guard_d - 6'd1;
    end else begin
      case (mode_d)
        MODE_IDLE: begin
          if (start_i) begin
            elapsed_d   = '0;
            drive_d     = 2'b01;
            lamp_d      = 1'b1;
            blink_red_d = 1'b0;
            if (flush_i) begin
              blink_en_d  = 1'b0;
              run_timer_d = cfg_i.max_flush_ms;
              mode_d      = MODE_FLUSH;
            end else begin
              blink_en_d    = 1'b1;
              blink_timer_d = cfg_i.blink_on_ms;
              run_timer_d   = run_time_i;
              mode_d        = MODE_RUN;
            end
            rel_wait_d = RW_START;
            suspended  = 1'b1;
            if (run_timer_d == '0) drive_d = drive_d & 2'b10;
          end
        end
        MODE_RUN: begin
          if (run_timer_d == '0) begin
            drive_d     = 2'b10;
            blink_en_d  = 1'b0;
            lamp_d      = 1'b0;
            run_timer_d = cfg_i.retract_ms;
            mode_d      = MODE_RETRACT;
          end
        end
        MODE_RETRACT: begin
          if (run_timer_d == '0) begin
            drive_d    = 2'b00;
            blink_en_d = 1'b0;
            lamp_d     = 1'b0;
            mode_d     = MODE_IDLE;
            total_d    = total_d + elapsed_d;
            runs_d     = runs_d + 32'd1;
            finished   = 1'b1;
          end
        end
        MODE_FLUSH: begin
          if (start_i || run_timer_d == '0) begin
            drive_d    = drive_d & 2'b10;
            blink_en_d = 1'b0;
            lamp_d     = 1'b0;
            if (start_i) begin
              rel_wait_d = RW_FLUSH;
              suspended  = 1'b1;
            end else begin
              mode_d   = MODE_IDLE;
              total_d  = total_d + elapsed_d;
              runs_d   = runs_d + 32'd1;
              finished = 1'b1;
            end
          end
        end
        MODE_STOP: begin
          if (!estop_i) begin
            blink_en_d = 1'b0;
            lamp_d     = 1'b0;
            mode_d     = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end

    if (!suspended && blink_en_d && blink_timer_d == '0) begin
      if (lamp_d) begin
        lamp_d        = 1'b0;
        blink_timer_d = cfg_i.blink_off_ms;
      end else begin
        lamp_d        = 1'b1;
        blink_timer_d = cfg_i.blink_on_ms;
      end
    end
  end

  always_comb begin : outputs
    res_o.pump_forward = drive_d[0];
    res_o.pump_reverse = drive_d[1];
    res_o.led_red      = lamp_d && blink_red_d;
    res_o.led_blue     = lamp_d && !blink_red_d;
    res_o.mode         = mode_d;
    res_o.run_finished = finished;
    res_o.total_run_ms = total_d;
    res_o.run_count    = runs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_STOP;
      rel_wait_q    <= RW_NONE;
      run_timer_q   <= '0;
      blink_timer_q <= '0;
      blink_en_q    <= 1'b0;
      lamp_q        <= 1'b0;
      blink_red_q   <= 1'b0;
      drive_q       <= 2'b00;
      guard_q       <= '0;
      elapsed_q     <= '0;
      total_q       <= '0;
      runs_q        <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      rel_wait_q    <= rel_wait_d;
      run_timer_q   <= run_timer_d;
      blink_timer_q <= blink_timer_d;
      blink_en_q    <= blink_en_d;
      lamp_q        <= lamp_d;
      blink_red_q   <= blink_red_d;
      drive_q       <= drive_d;
      guard_q       <= guard_d;
      elapsed_q     <= elapsed_d;
      total_q       <= total_d;
      runs_q        <= runs_d;
    end
  end

  a_guard_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_q != '0 |-> rel_wait_q == RW_NONE)
    else $error("guard running while waiting for release");

  a_flush_wait_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_wait_q == RW_FLUSH |-> mode_q == MODE_FLUSH)
    else $error("flush end wait outside flushing");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && finished |=> runs_q == $past(runs_q) + 32'd1)
    else $error("run count not advanced on finished run");

endmodule

// ----- src/pump_fill_sequencer.sv -----
// ----------------------------------------------------------------------------
// pump_fill_sequencer
// pump fill sequencer stepped by one 1 ms tick item
//
//   channel   signals                                 direction
//   in        in_valid_i / in_ready_o, tick fields    sink
//   out       out_valid_o / out_ready_i, result       source
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i        sink, write only
//
// one item per cycle sustained unless the result stalls; the level scaling
// multiply sits before the input register, which feeds the result register
// reset puts the sequencer in stop mode with zero totals and default config
// a stalled result holds in the result register while the next item waits in
// the input register; in_ready_o drops only when both are full and stalled
// ----------------------------------------------------------------------------
module pump_fill_sequencer
  import pfs_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 start_pressed_i,
  input  logic                 flush_selected_i,
  input  logic                 estop_active_i,
  input  logic [LEVEL_W-1:0]   level_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 pump_forward_o,
  output logic                 pump_reverse_o,
  output logic                 led_red_o,
  output logic                 led_blue_o,
  output logic [2:0]           mode_o,
  output logic                 run_finished_o,
  output logic [31:0]          total_run_ms_o,
  output logic [31:0]          run_count_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t        cfg;
  logic [15:0] run_time;
  res_t        res;

  logic        s1_valid_q;
  logic        s1_start_q;
  logic        s1_flush_q;
  logic        s1_estop_q;
  logic [15:0] s1_run_time_q;
  logic        out_valid_q;
  res_t        res_q;

  logic        out_free;
  logic        step;
  logic        in_acc;

  pfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pfs_scale #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_scale (
    .level_i    (level_i),
    .max_run_i  (cfg.max_run_ms),
    .run_time_o (run_time)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_start_q    <= start_pressed_i;
      s1_flush_q    <= flush_selected_i;
      s1_estop_q    <= estop_active_i;
      s1_run_time_q <= run_time;
    end
  end

  pfs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .start_i    (s1_start_q),
    .flush_i    (s1_flush_q),
    .estop_i    (s1_estop_q),
    .run_time_i (s1_run_time_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pump_forward_o = res_q.pump_forward;
  assign pump_reverse_o = res_q.pump_reverse;
  assign led_red_o      = res_q.led_red;
  assign led_blue_o     = res_q.led_blue;
  assign mode_o         = res_q.mode;
  assign run_finished_o = res_q.run_finished;
  assign total_run_ms_o = res_q.total_run_ms;
  assign run_count_o    = res_q.run_count;

  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(led_red_o && led_blue_o))
    else $error("red and blue lamps lit together");

  a_one_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pump_forward_o && pump_reverse_o))
    else $error("forward and reverse drive together");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_finished_o |-> mode_o == MODE_IDLE)
    else $error("run finished outside idle mode");

endmodule

// ----- bench/pump_fill_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_fill_sequencer_tb
// self-checking bench for the pump fill sequencer: a queue-fed driver sends
// 1 ms tick items (button presses, flush, stop, level), a shadow copy of the
// sequencer predicts each output item, and the monitor compares every field
// over several register settings with random idling and backpressure
// ----------------------------------------------------------------------------
module pump_fill_sequencer_tb;
  import pfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic               start;
    logic               flush;
    logic               estop;
    logic [LEVEL_W-1:0] level;
  } tick_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic               start_pressed_i  = 1'b0;
  logic               flush_selected_i = 1'b0;
  logic               estop_active_i   = 1'b0;
  logic [LEVEL_W-1:0] level_i          = '0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic               pump_forward_o;
  logic               pump_reverse_o;
  logic               led_red_o;
  logic               led_blue_o;
  logic [2:0]         mode_o;
  logic               run_finished_o;
  logic [31:0]        total_run_ms_o;
  logic [31:0]        run_count_o;
  logic               cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [CFG_W-1:0]   cfg_wdata_i      = '0;

  pump_fill_sequencer dut (.*);

  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  tick_t tick_backlog[$];
  res_t  predicted_outputs[$];

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  logic  send_hold     = 1'b0;
  int    mismatches    = 0;
  int    rx_count      = 0;
  int    stall_left    = 0;
  int    cycles        = 0;

  // shadow sequencer state
  cfg_t        seq_cfg;
  mode_e       seq_mode;
  logic [15:0] run_tmr;
  logic [7:0]  blink_tmr;
  logic        blink_on;
  logic        lamp;
  logic        red_lamp;
  logic [1:0]  drive;
  rel_wait_e   rel_wait;
  logic [5:0]  guard_tmr;
  logic [31:0] elapsed;
  logic [31:0] total;
  logic [31:0] runs;

  task automatic close_run(output logic fin);
    total = total + elapsed;
    runs  = runs + 32'd1;
    fin   = 1'b1;
  endtask

  task automatic advance_sequencer(input tick_t t, output res_t r);
    logic        fin;
    logic        susp;
    logic [27:0] prod;
    fin  = 1'b0;
    susp = 1'b0;
    if (run_tmr != 16'd0) run_tmr = run_tmr - 16'd1;
    if (blink_tmr != 8'd0) blink_tmr = blink_tmr - 8'd1;
    if (seq_mode == MODE_RUN || seq_mode == MODE_RETRACT || seq_mode == MODE_FLUSH)
      elapsed = elapsed + 32'd1;

    if (t.estop) begin
      blink_on  = 1'b0;
      lamp      = 1'b1;
      red_lamp  = 1'b1;
      drive     = 2'b00;
      seq_mode  = MODE_STOP;
      rel_wait  = RW_NONE;
      guard_tmr = '0;
    end

    if (rel_wait == RW_START) begin
      susp = 1'b1;
      if (run_tmr == 16'd0) drive[0] = 1'b0;
      if (!t.start) begin
        rel_wait  = RW_NONE;
        guard_tmr = GUARD_MS;
      end
    end else if (rel_wait == RW_FLUSH) begin
      susp = 1'b1;
      if (!t.start) begin
        rel_wait = RW_NONE;
        seq_mode = MODE_IDLE;
        close_run(fin);
      end
    end else if (guard_tmr != 6'd0) begin
      susp      = 1'b1;
      guard_tmr = guard_tmr - 6'd1;
    end else begin
      case (seq_mode)
        MODE_IDLE: begin
          if (t.start) begin
            elapsed  = '0;
            drive    = 2'b01;
            lamp     = 1'b1;
            red_lamp = 1'b0;
            if (t.flush) begin
              blink_on = 1'b0;
              run_tmr  = seq_cfg.max_flush_ms;
              seq_mode = MODE_FLUSH;
            end else begin
              blink_on  = 1'b1;
              blink_tmr = seq_cfg.blink_on_ms;
              prod      = 28'(t.level) * 28'(seq_cfg.max_run_ms);
              run_tmr   = prod[27:12];
              seq_mode  = MODE_RUN;
            end
            rel_wait = RW_START;
            susp     = 1'b1;
            if (run_tmr == 16'd0) drive[0] = 1'b0;
          end
        end
        MODE_RUN: begin
          if (run_tmr == 16'd0) begin
            drive    = 2'b10;
            blink_on = 1'b0;
            lamp     = 1'b0;
            run_tmr  = seq_cfg.retract_ms;
            seq_mode = MODE_RETRACT;
          end
        end
        MODE_RETRACT: begin
          if (run_tmr == 16'd0) begin
            drive    = 2'b00;
            blink_on = 1'b0;
            lamp     = 1'b0;
            seq_mode = MODE_IDLE;
            close_run(fin);
          end
        end
        MODE_FLUSH: begin
          if (t.start || run_tmr == 16'd0) begin
            drive[0] = 1'b0;
            blink_on = 1'b0;
            lamp     = 1'b0;
            if (t.start) begin
              rel_wait = RW_FLUSH;
              susp     = 1'b1;
            end else begin
              seq_mode = MODE_IDLE;
              close_run(fin);
            end
          end
        end
        MODE_STOP: begin
          if (!t.estop) begin
            blink_on = 1'b0;
            lamp     = 1'b0;
            seq_mode = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end

    if (!susp && blink_on && blink_tmr == 8'd0) begin
      if (lamp) begin
        lamp      = 1'b0;
        blink_tmr = seq_cfg.blink_off_ms;
      end else begin
        lamp      = 1'b1;
        blink_tmr = seq_cfg.blink_on_ms;
      end
    end

    r.pump_forward = drive[0];
    r.pump_reverse = drive[1];
    r.led_red      = lamp & red_lamp;
    r.led_blue     = lamp & ~red_lamp;
    r.mode         = seq_mode;
    r.run_finished = fin;
    r.total_run_ms = total;
    r.run_count    = runs;
  endtask

  task automatic push_tick(input logic s, input logic f, input logic e,
                           input logic [LEVEL_W-1:0] l);
    tick_t t;
    t.start = s;
    t.flush = f;
    t.estop = e;
    t.level = l;
    tick_backlog.push_back(t);
  endtask

  // presses of random length with random gaps, plus some fully random ticks
  task automatic queue_ticks(input int n);
    int                 hold;
    int                 gap;
    int                 k;
    logic               fl;
    logic [LEVEL_W-1:0] lvl;
    while (n > 0) begin
      fl = 1'($urandom_range(1, 0));
      case ($urandom_range(3, 0))
        0: lvl = LEVEL_W'($urandom);
        1: lvl = LEVEL_W'($urandom_range(300, 0));
        2: lvl = LEVEL_W'($urandom_range(40, 0));
        default: lvl = $urandom_range(1, 0) ? '1 : '0;
      endcase
      hold = ($urandom_range(9, 0) == 0) ? $urandom_range(90, 5) : $urandom_range(4, 1);
      gap  = $urandom_range(160, 0);
      for (k = 0; k < hold + gap && n > 0; k++) begin
        if ($urandom_range(7, 0) == 0)
          push_tick(1'($urandom), 1'($urandom), $urandom_range(24, 0) == 0,
                    LEVEL_W'($urandom));
        else
          push_tick(k < hold, fl, $urandom_range(249, 0) == 0,
                    (k == 0) ? lvl : LEVEL_W'($urandom));
        n--;
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_MAX_RUN:   seq_cfg.max_run_ms   = val;
      REG_MAX_FLUSH: seq_cfg.max_flush_ms = val;
      REG_RETRACT:   seq_cfg.retract_ms   = val;
      REG_BLINK_ON:  seq_cfg.blink_on_ms  = val[7:0];
      REG_BLINK_OFF: seq_cfg.blink_off_ms = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (tick_backlog.size() != 0 || in_valid_i || predicted_outputs.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i) begin : drive_p
    tick_t nxt;
    res_t  want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_sequencer({start_pressed_i, flush_selected_i, estop_active_i, level_i},
                          want);
        predicted_outputs.push_back(want);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tick_backlog.size() != 0 && !send_hold &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = tick_backlog.pop_front();
          start_pressed_i  <= nxt.start;
          flush_selected_i <= nxt.flush;
          estop_active_i   <= nxt.estop;
          level_i          <= nxt.level;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_p
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          $error("output item with no tick item pending");
        end else begin
          want = predicted_outputs.pop_front();
          check_field("pump_forward", 32'(want.pump_forward), 32'(pump_forward_o));
          check_field("pump_reverse", 32'(want.pump_reverse), 32'(pump_reverse_o));
          check_field("led_red", 32'(want.led_red), 32'(led_red_o));
          check_field("led_blue", 32'(want.led_blue), 32'(led_blue_o));
          check_field("mode", 32'(want.mode), 32'(mode_o));
          check_field("run_finished", 32'(want.run_finished), 32'(run_finished_o));
          check_field("total_run_ms", want.total_run_ms, total_run_ms_o);
          check_field("run_count", want.run_count, run_count_o);
        end
        rx_count++;
        // long hold-off so the block fills and stalls its input
        if (rx_count == 300 || rx_count == 1500) stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pump_fill_sequencer test failed");
      $finish;
    end
  end

  initial begin
    int          p;
    int          n;
    logic [15:0] cr;
    logic [15:0] cf;
    logic [15:0] ct;
    logic [7:0]  bon;
    logic [7:0]  boff;

    seq_cfg.max_run_ms   = MAX_RUN_RST;
    seq_cfg.max_flush_ms = MAX_FLUSH_RST;
    seq_cfg.retract_ms   = RETRACT_RST;
    seq_cfg.blink_on_ms  = BLINK_ON_RST;
    seq_cfg.blink_off_ms = BLINK_OFF_RST;
    seq_mode  = MODE_STOP;
    run_tmr   = '0;
    blink_tmr = '0;
    blink_on  = 1'b0;
    lamp      = 1'b0;
    red_lamp  = 1'b0;
    drive     = 2'b00;
    rel_wait  = RW_NONE;
    guard_tmr = '0;
    elapsed   = '0;
    total     = '0;
    runs      = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks at reset settings
    send_idle_pct <= 6;
    recv_idle_pct <= 83;
    push_tick(1'b0, 1'b0, 1'b1, '1);       // stop held
    push_tick(1'b1, 1'b1, 1'b1, '0);       // stop wins over start
    push_tick(1'b0, 1'b0, 1'b0, '0);       // stop released
    push_tick(1'b1, 1'b0, 1'b0, '1);       // full-scale run
    push_tick(1'b1, 1'b1, 1'b0, '1);
    push_tick(1'b0, 1'b0, 1'b0, '0);       // release, guard begins
    push_tick(1'b0, 1'b0, 1'b1, '0);       // stop in guard
    push_tick(1'b0, 1'b0, 1'b0, '0);
    push_tick(1'b1, 1'b1, 1'b0, '0);       // flush
    push_tick(1'b1, 1'b0, 1'b0, '0);
    push_tick(1'b0, 1'b0, 1'b1, '0);       // stop in release wait
    push_tick(1'b0, 1'b0, 1'b0, '0);
    push_tick(1'b1, 1'b0, 1'b0, '0);       // zero run time
    push_tick(1'b0, 1'b0, 1'b0, '1);
    push_tick(1'b0, 1'b1, 1'b1, '0);
    push_tick(1'b0, 1'b0, 1'b0, '0);
    push_tick(1'b1, 1'b1, 1'b0, 12'h800);
    push_tick(1'b0, 1'b0, 1'b0, '0);
    push_tick(1'b1, 1'b1, 1'b1, '1);
    push_tick(1'b0, 1'b1, 1'b0, 12'h001);
    push_tick(1'b1, 1'b0, 1'b0, 12'h001);  // short run
    push_tick(1'b0, 1'b0, 1'b0, '0);
    drain();

    for (p = 1; p <= 7; p++) begin
      case (p)
        1: begin cr = 16'd200;   cf = 16'd120;   ct = 16'd20;    bon = 8'd3;   boff = 8'd2;   end
        2: begin cr = 16'd0;     cf = 16'd0;     ct = 16'd0;     bon = 8'd1;   boff = 8'd1;   end
        3: begin cr = 16'hFFFF;  cf = 16'hFFFF;  ct = 16'hFFFF;  bon = 8'd255; boff = 8'd255; end
        4: begin cr = 16'd1000;  cf = 16'd300;   ct = 16'd5;     bon = 8'd0;   boff = 8'd7;   end
        5: begin cr = 16'd4096;  cf = 16'd60;    ct = 16'd30;    bon = 8'd5;   boff = 8'd0;   end
        6: begin cr = 16'd300;   cf = 16'd200;   ct = 16'd1;     bon = 8'd2;   boff = 8'd9;   end
        default: begin
          cr = MAX_RUN_RST; cf = MAX_FLUSH_RST; ct = RETRACT_RST;
          bon = BLINK_ON_RST; boff = BLINK_OFF_RST;
        end
      endcase
      send_idle_pct <= (p <= 2) ? 6 : (p <= 4) ? 83 : 0;
      recv_idle_pct <= (p <= 2) ? 83 : (p <= 4) ? 6 : 0;
      write_reg(REG_MAX_RUN, cr);
      write_reg(REG_MAX_FLUSH, cf);
      write_reg(REG_RETRACT, ct);
      write_reg(REG_BLINK_ON, {8'($urandom), bon});
      write_reg(REG_BLINK_OFF, {8'($urandom), boff});
      @(posedge clk_i);
      cfg_we_i <= 1'b0;

      n = 270;
      queue_ticks(n);
      if (p == 5) begin
        // sender pause until all outputs are back
        while (tick_backlog.size() > n / 2) @(posedge clk_i);
        send_hold <= 1'b1;
        @(posedge clk_i);
        while (in_valid_i || predicted_outputs.size() != 0) @(posedge clk_i);
        send_hold <= 1'b0;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("pump_fill_sequencer test passed");
    else
      $display("pump_fill_sequencer test failed");
    $finish;
  end

endmodule
